// ===== rtl/u16u8_pkg.sv =====
// Package for the UTF-16 to UTF-8 transcoder: the run descriptor type,
// the surrogate and error codes, and the UTF-8 encoding function.
// Has no dependencies; the decoder, serialiser and top level use it.
package u16u8_pkg;

    // Error codes carried on a result.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_STRAY_LOW = 2'd1;
    localparam logic [1:0] ERR_MISS_LOW  = 2'd2;
    localparam logic [1:0] ERR_TRUNC_END = 2'd3;

    // Top six bits that identify high (0xD800..0xDBFF) and low (0xDC00..0xDFFF)
    // surrogates.
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

    // Offset added to a combined surrogate pair.
    localparam logic [20:0] CP_SUPP_BASE = 21'h10000;

    // Upper limits of the one, two and three byte forms.
    localparam logic [20:0] CP_MAX_1B = 21'h7F;
    localparam logic [20:0] CP_MAX_2B = 21'h7FF;
    localparam logic [20:0] CP_MAX_3B = 21'hFFFF;

    // Lead byte prefixes and the continuation prefix.
    localparam logic [2:0] LEAD_2B = 3'b110;
    localparam logic [3:0] LEAD_3B = 4'b1110;
    localparam logic [4:0] LEAD_4B = 5'b11110;
    localparam logic [1:0] CONT_B  = 2'b10;

    // One decoded input: up to four bytes, the index of the last one, and flags.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            string_end;
        logic [1:0]      err;
    } run_t;

    // Builds an error run: one zero byte carrying the error code.
    function automatic run_t error_run(input logic [1:0] code, input logic end_flag);
        run_t r;
        r            = '0;
        r.err        = code;
        r.string_end = end_flag;
        return r;
    endfunction

    // Encodes a code point as a UTF-8 byte run.
    function automatic run_t encode_cp(input logic [20:0] cp, input logic end_flag);
        run_t r;
        r            = '0;
        r.err        = ERR_NONE;
        r.string_end = end_flag;
        priority if (cp <= CP_MAX_1B) begin
            r.bytes[0] = cp[7:0];
            r.last_idx = 2'd0;
        end else if (cp <= CP_MAX_2B) begin
            r.bytes[0] = {LEAD_2B, cp[10:6]};
            r.bytes[1] = {CONT_B, cp[5:0]};
            r.last_idx = 2'd1;
        end else if (cp <= CP_MAX_3B) begin
            r.bytes[0] = {LEAD_3B, cp[15:12]};
            r.bytes[1] = {CONT_B, cp[11:6]};
            r.bytes[2] = {CONT_B, cp[5:0]};
            r.last_idx = 2'd2;
        end else begin
            r.bytes[0] = {LEAD_4B, cp[20:18]};
            r.bytes[1] = {CONT_B, cp[17:12]};
            r.bytes[2] = {CONT_B, cp[11:6]};
            r.bytes[3] = {CONT_B, cp[5:0]};
            r.last_idx = 2'd3;
        end
        return r;
    endfunction

endpackage

// ===== rtl/u16u8_decoder.sv =====
// Surrogate tracking and code point decoding for the transcoder.
// Holds the pending high surrogate; depends on u16u8_pkg.
module u16u8_decoder (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [15:0]      code_unit,
    input  logic             string_end,
    output logic             has_run,
    output u16u8_pkg::run_t  run
);

    logic [9:0] held_reg, held_next;
    logic       pending_reg, pending_next;
    logic       is_high, is_low;
    logic [20:0] pair_cp;

    assign is_high = (code_unit[15:10] == u16u8_pkg::SURR_HIGH_TAG);
    assign is_low  = (code_unit[15:10] == u16u8_pkg::SURR_LOW_TAG);
    assign pair_cp = {1'b0, held_reg, code_unit[9:0]} + u16u8_pkg::CP_SUPP_BASE;

    // Classify the unit against the pending state and build its byte run.
    always_comb begin
        has_run      = 1'b1;
        held_next    = held_reg;
        pending_next = pending_reg;
        run          = u16u8_pkg::encode_cp({5'd0, code_unit}, string_end);
        priority if (pending_reg) begin
            pending_next = 1'b0;
            held_next    = '0;
            if (is_low) begin
                run = u16u8_pkg::encode_cp(pair_cp, string_end);
            end else begin
                run = u16u8_pkg::error_run(u16u8_pkg::ERR_MISS_LOW, string_end);
            end
        end else if (is_low) begin
            run = u16u8_pkg::error_run(u16u8_pkg::ERR_STRAY_LOW, string_end);
        end else if (is_high) begin
            if (string_end) begin
                run = u16u8_pkg::error_run(u16u8_pkg::ERR_TRUNC_END, string_end);
            end else begin
                has_run      = 1'b0;
                held_next    = code_unit[9:0];
                pending_next = 1'b1;
            end
        end else begin
            // A plain BMP unit is encoded on its own.
            run = u16u8_pkg::encode_cp({5'd0, code_unit}, string_end);
        end
    end

    // Surrogate state advances on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            held_reg    <= '0;
        end else if (accept) begin
            pending_reg <= pending_next;
            held_reg    <= held_next;
        end
    end

endmodule

// ===== rtl/u16u8_serializer.sv =====
// Run register and output register of the transcoder: sends one byte of
// the held run per transaction. Depends on u16u8_pkg.
module u16u8_serializer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  u16u8_pkg::run_t  run_in,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic             out_done,
    output logic [1:0]       out_err
);

    u16u8_pkg::run_t run_reg;
    logic            run_valid_reg;
    logic [1:0]      idx_reg;
    logic            out_valid_reg;
    logic [7:0]      byte_reg;
    logic            last_reg, done_reg;
    logic [1:0]      err_reg;
    logic            out_load, at_last, run_drain;

    assign out_load  = run_valid_reg && (!out_valid_reg || out_ready);
    assign at_last   = (idx_reg == run_reg.last_idx);
    assign run_drain = out_load && at_last;
    assign in_ready  = !run_valid_reg || run_drain;

    // Run register: loaded from the decoder, freed when its last byte moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (load) begin
                run_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (run_drain) begin
                run_valid_reg <= 1'b0;
            end else if (out_load) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            run_reg <= run_in;
        end
    end

    // Output register holds one result until the downstream side takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            byte_reg <= run_reg.bytes[idx_reg];
            last_reg <= at_last;
            done_reg <= at_last && run_reg.string_end;
            err_reg  <= run_reg.err;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_done  = done_reg;
    assign out_err   = err_reg;

endmodule

// ===== rtl/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder.
// Instantiates u16u8_decoder and u16u8_serializer; uses u16u8_pkg.
//
// Channel   Direction  tdata          tlast       tuser
// s_axis    in         code_unit[15:0] string_end  -
// m_axis    out        out_byte[7:0]  run_last    {error_code[1:0], string_done}
//
// A code unit is decoded as it is accepted and its bytes are held in a run
// register; each byte then passes through an output register. While m_axis is
// ready, bytes move one per cycle, and one-byte results and errors flow at one
// code unit per cycle; a longer run holds the run register until its last byte
// moves on, and input waits until then. A held high surrogate gives no result.
// Reset (aresetn low, synchronous) clears the pending surrogate and both
// valid flags. Stalls on m_axis back up through the output and run registers.
module utf16_to_utf8_transcoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  logic        s_axis_tlast,   // string_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // run_last
    output logic [2:0]  m_axis_tuser    // [0] string_done, [2:1] error_code
);

    logic            s_accept;
    logic            has_run;
    u16u8_pkg::run_t run;
    logic            out_done;
    logic [1:0]      out_err;

    assign s_accept = s_axis_tvalid && s_axis_tready;

    // Surrogate handling and code point encoding.
    u16u8_decoder u_decoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .code_unit  (s_axis_tdata),
        .string_end (s_axis_tlast),
        .has_run    (has_run),
        .run        (run)
    );

    // Byte-by-byte delivery of each run.
    u16u8_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_accept && has_run),
        .run_in    (run),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_done  (out_done),
        .out_err   (out_err)
    );

    assign m_axis_tuser = {out_err, out_done};

`ifndef NO_ASSERTIONS
    // An error result is a single zero byte that closes its run.
    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser[2:1] != u16u8_pkg::ERR_NONE)
        |-> m_axis_tlast && (m_axis_tdata == 8'd0))
        else $error("error result is not a lone zero byte");

    // The string-done flag only appears on the last byte of a run.
    a_done_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("string_done set on a byte that is not the last");

    // After reset the block is empty and ready for input.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not empty after reset");

    // A continuation byte always follows within the same run.
    a_cont_not_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> !m_axis_tvalid || (m_axis_tdata[7:6] == u16u8_pkg::CONT_B))
        else $error("run continued with a non-continuation byte");
`endif

endmodule

// ===== tb/utf16_to_utf8_transcoder_tb.sv =====
// Self-checking testbench for the UTF-16 to UTF-8 transcoder.
// Drives code units on s_axis, predicts the UTF-8 byte stream and checks m_axis.
// Depends on u16u8_pkg and the utf16_to_utf8_transcoder top level only.
`timescale 1ns / 100ps

module utf16_to_utf8_transcoder_tb;

    localparam int  CLK_HALF     = 10;
    localparam int  RESET_CYCLES = 7;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  RANDOM_UNITS = 140;
    localparam int  HOLD_CYCLES  = 60;
    localparam int  PRINT_LIMIT  = 100;

    // Lead byte prefixes of the multi-byte forms, built from the package tags.
    localparam logic [7:0] LEAD2_PREFIX = {u16u8_pkg::LEAD_2B, 5'd0};
    localparam logic [7:0] LEAD3_PREFIX = {u16u8_pkg::LEAD_3B, 4'd0};
    localparam logic [7:0] LEAD4_PREFIX = {u16u8_pkg::LEAD_4B, 3'd0};
    localparam logic [7:0] CONT_PREFIX  = {u16u8_pkg::CONT_B, 6'd0};

    // One expected output byte and its flags.
    typedef struct {
        logic [7:0] value;
        logic       run_last;
        logic       string_done;
        logic [1:0] err;
    } utf8_byte_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic [15:0] s_data;
    logic        s_last;
    logic        m_ready;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;

    // Predictor state: the held high surrogate.
    logic [9:0]  held_surrogate_bits;
    logic        surrogate_pending;

    utf8_byte_t  expected_bytes[$];
    utf8_byte_t  expected_head;
    int          mismatch_count;
    int          units_sent;
    int          hold_request;
    bit          no_idle;

    utf16_to_utf8_transcoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    // Prints one line per mismatch, up to PRINT_LIMIT, and keeps count.
    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Queues a single error result and drops any held surrogate.
    task automatic push_error_byte(input logic [1:0] code, input logic last_unit);
        utf8_byte_t b;
        b.value       = 8'd0;
        b.run_last    = 1'b1;
        b.string_done = last_unit;
        b.err         = code;
        expected_bytes.insert(expected_bytes.size(), b);
        surrogate_pending   = 1'b0;
        held_surrogate_bits = '0;
    endtask

    // Queues the UTF-8 encoding of one code point, six payload bits per
    // continuation byte, lead byte first.
    task automatic push_code_point(input logic [20:0] cp, input logic last_unit);
        utf8_byte_t b;
        int         n;
        logic [20:0] shifted;
        if (cp <= u16u8_pkg::CP_MAX_1B) begin
            n = 1;
        end else if (cp <= u16u8_pkg::CP_MAX_2B) begin
            n = 2;
        end else if (cp <= u16u8_pkg::CP_MAX_3B) begin
            n = 3;
        end else begin
            n = 4;
        end
        for (int k = 0; k < n; k++) begin
            shifted = cp >> (6 * (n - 1 - k));
            if (k > 0) begin
                b.value = CONT_PREFIX | {2'b00, shifted[5:0]};
            end else begin
                case (n)
                    1: b.value = shifted[7:0];
                    2: b.value = LEAD2_PREFIX | {3'b000, shifted[4:0]};
                    3: b.value = LEAD3_PREFIX | {4'b0000, shifted[3:0]};
                    default: b.value = LEAD4_PREFIX | {5'b00000, shifted[2:0]};
                endcase
            end
            b.run_last    = (k == n - 1);
            b.string_done = (k == n - 1) ? last_unit : 1'b0;
            b.err         = u16u8_pkg::ERR_NONE;
            expected_bytes.insert(expected_bytes.size(), b);
        end
    endtask

    // Works out the results of one accepted code unit.
    task automatic predict_utf8(input logic [15:0] cu, input logic last_unit);
        logic is_high;
        logic is_low;
        is_high = (cu[15:10] == u16u8_pkg::SURR_HIGH_TAG);
        is_low  = (cu[15:10] == u16u8_pkg::SURR_LOW_TAG);
        if (surrogate_pending) begin
            if (!is_low) begin
                push_error_byte(u16u8_pkg::ERR_MISS_LOW, last_unit);
            end else begin
                surrogate_pending = 1'b0;
                push_code_point({1'b0, held_surrogate_bits, cu[9:0]}
                                + u16u8_pkg::CP_SUPP_BASE, last_unit);
                held_surrogate_bits = '0;
            end
        end else if (is_low) begin
            push_error_byte(u16u8_pkg::ERR_STRAY_LOW, last_unit);
        end else if (is_high) begin
            if (last_unit) begin
                push_error_byte(u16u8_pkg::ERR_TRUNC_END, last_unit);
            end else begin
                held_surrogate_bits = cu[9:0];
                surrogate_pending   = 1'b1;
            end
        end else begin
            push_code_point({5'd0, cu}, last_unit);
        end
    endtask

    // Offers one code unit after a random gap and waits for the transaction.
    // Called right after a rising edge; valid stays high for a back-to-back unit.
    task automatic send_code_unit(input logic [15:0] cu, input logic last_unit);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cu;
        s_last  <= last_unit;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_utf8(cu, last_unit);
        units_sent++;
    endtask

    // Sends a code point as one unit or as a surrogate pair.
    task automatic send_code_point(input logic [20:0] cp, input logic last_unit);
        logic [19:0] offset;
        if (cp > u16u8_pkg::CP_MAX_3B) begin
            offset = 20'(cp - u16u8_pkg::CP_SUPP_BASE);
            send_code_unit({u16u8_pkg::SURR_HIGH_TAG, offset[19:10]}, 1'b0);
            send_code_unit({u16u8_pkg::SURR_LOW_TAG, offset[9:0]}, last_unit);
        end else begin
            send_code_unit(cp[15:0], last_unit);
        end
    endtask

    // Lowers valid and waits until every expected byte has come out.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Draws a code point from one of the four encoded lengths.
    function automatic logic [20:0] random_code_point();
        logic [20:0] cp;
        case ($urandom_range(0, 3))
            0: cp = 21'($urandom_range(0, 16'h007F));
            1: cp = 21'($urandom_range(16'h0080, 16'h07FF));
            2: begin
                cp = 21'($urandom_range(16'h0800, 16'hFFFF));
                if (cp[15:11] == 5'b11011) cp[15:11] = 5'b11100;
            end
            default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
        return cp;
    endfunction

    // Sends one malformed or arbitrary unit.
    task automatic send_noise_unit();
        case ($urandom_range(0, 3))
            0: send_code_unit(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
            1: send_code_unit({u16u8_pkg::SURR_LOW_TAG, 10'($urandom_range(0, 1023))},
                              1'($urandom_range(0, 1)));
            2: send_code_unit({u16u8_pkg::SURR_HIGH_TAG, 10'($urandom_range(0, 1023))},
                              1'b0);
            default: send_code_unit({u16u8_pkg::SURR_HIGH_TAG,
                                     10'($urandom_range(0, 1023))}, 1'b1);
        endcase
    endtask

    // Sends one well-formed string, sometimes with noise mixed in.
    task automatic send_random_string();
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 15) begin
                send_noise_unit();
            end else begin
                send_code_point(random_code_point(), i == len - 1);
            end
        end
    endtask

    // Boundaries of each encoded length and every kind of malformed sequence.
    task automatic test_directed_boundaries();
        send_code_unit(16'h0000, 1'b0);
        send_code_unit(16'h007F, 1'b1);
        send_code_unit(16'h0080, 1'b0);
        send_code_unit(16'h07FF, 1'b1);
        send_code_unit(16'h0800, 1'b0);
        send_code_unit(16'hD7FF, 1'b0);
        send_code_unit(16'hE000, 1'b0);
        send_code_unit(16'hFFFF, 1'b1);
        // Lowest and highest supplementary code points.
        send_code_unit(16'hD800, 1'b0);
        send_code_unit(16'hDC00, 1'b0);
        send_code_unit(16'hDBFF, 1'b0);
        send_code_unit(16'hDFFF, 1'b1);
        // Stray low surrogates.
        send_code_unit(16'hDC00, 1'b0);
        send_code_unit(16'hDFFF, 1'b1);
        // A high surrogate followed by a plain unit, then by another high one.
        send_code_unit(16'hD800, 1'b0);
        send_code_unit(16'h0041, 1'b0);
        send_code_unit(16'hDBFF, 1'b0);
        send_code_unit(16'hD800, 1'b0);
        // A missing low surrogate on the last unit of a string.
        send_code_unit(16'hDABC, 1'b0);
        send_code_unit(16'hFFFF, 1'b1);
        // A high surrogate that ends the string.
        send_code_unit(16'hDBC0, 1'b1);
        send_code_unit(16'h5555, 1'b1);
        send_code_unit(16'hAAAA, 1'b0);
        wait_for_drain();
    endtask

    // Random strings, the first stretch with no idling on either side.
    task automatic test_random_strings();
        int start;
        start   = units_sent;
        no_idle = 1'b1;
        while (units_sent < start + RANDOM_UNITS) begin
            if (units_sent >= start + 40) no_idle = 1'b0;
            send_random_string();
        end
        no_idle = 1'b0;
        wait_for_drain();
    endtask

    // The receiver holds off for a long stretch while long runs keep coming.
    task automatic test_output_backpressure();
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 20; i++) begin
            send_code_point(21'($urandom_range(21'h10000, 21'h10FFFF)), i == 19);
        end
        wait_for_drain();
    endtask

    // The sender stops, with a surrogate held, until all output has come.
    task automatic test_sender_pause();
        send_code_point(random_code_point(), 1'b0);
        send_code_unit({u16u8_pkg::SURR_HIGH_TAG, 10'($urandom_range(0, 1023))}, 1'b0);
        wait_for_drain();
        send_code_unit({u16u8_pkg::SURR_LOW_TAG, 10'($urandom_range(0, 1023))}, 1'b1);
        send_code_point(random_code_point(), 1'b1);
        wait_for_drain();
    endtask

    // Receiver: random ready gaps and the occasional long hold-off.
    initial begin
        int wait_cycles;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request > 0) begin
                wait_cycles  = hold_request;
                hold_request = 0;
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            wait_cycles = no_idle ? 0 : $urandom_range(0, 3);
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
        end
    end

    // Checks every output transaction against the oldest expected byte.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", m_axis_tdata));
            end else begin
                expected_head = expected_bytes.pop_front();
                if (m_axis_tdata !== expected_head.value)
                    report_mismatch($sformatf("byte %02h, expected %02h",
                                              m_axis_tdata, expected_head.value));
                if (m_axis_tlast !== expected_head.run_last)
                    report_mismatch($sformatf("run_last %b, expected %b",
                                              m_axis_tlast, expected_head.run_last));
                if (m_axis_tuser[0] !== expected_head.string_done)
                    report_mismatch($sformatf("string_done %b, expected %b",
                                              m_axis_tuser[0], expected_head.string_done));
                if (m_axis_tuser[2:1] !== expected_head.err)
                    report_mismatch($sformatf("error_code %0d, expected %0d",
                                              m_axis_tuser[2:1], expected_head.err));
            end
        end
    end

    // Overall time limit.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Reset, the test sequence and the verdict.
    initial begin
        aresetn             = 1'b0;
        s_valid             = 1'b0;
        s_data              = '0;
        s_last              = 1'b0;
        held_surrogate_bits = '0;
        surrogate_pending   = 1'b0;
        mismatch_count      = 0;
        units_sent          = 0;
        hold_request        = 0;
        no_idle             = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_boundaries();
        test_random_strings();
        test_output_backpressure();
        test_sender_pause();

        if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/u16u8_pkg.sv
rtl/u16u8_decoder.sv
rtl/u16u8_serializer.sv
rtl/utf16_to_utf8_transcoder.sv
tb/utf16_to_utf8_transcoder_tb.sv
